/* design/swcm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stream window credit manager.
// No dependencies; every other design file imports this package.
package swcm_pkg;

   localparam int WIN_W  = 32;   // signed credit window
   localparam int SID_W  = 31;   // stream identifier
   localparam int INC_W  = 32;   // received window update increment
   localparam int LEN_W  = 24;   // data length
   localparam int IWIN_W = 31;   // initial window register

   localparam logic [IWIN_W-1:0] DEFAULT_WINDOW = 31'd65535;

   // event kinds
   localparam logic [2:0] KIND_INIT   = 3'd0;
   localparam logic [2:0] KIND_OPEN   = 3'd1;
   localparam logic [2:0] KIND_UPDATE = 3'd2;
   localparam logic [2:0] KIND_CHECK  = 3'd3;
   localparam logic [2:0] KIND_SEND   = 3'd4;
   localparam logic [2:0] KIND_RECV   = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BLOCKED = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_LOAD,
      ST_EXEC,
      ST_RECV_SLOT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [SID_W-1:0] sid;
      logic [WIN_W-1:0] send_win;
      logic [WIN_W-1:0] recv_win;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             update_valid;
      logic [SID_W-1:0] update_sid;
      logic [SID_W-1:0] update_inc;
      logic             last;
   } rsp_type;

endpackage

/* design/swcm_slot_mem.sv */
`timescale 1ns / 1ps
// Slot table memory: stream id, send window and receive window per slot.
// One write port, one read port with registered read data. Uses swcm_pkg.
module swcm_slot_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  swcm_pkg::slot_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output swcm_pkg::slot_entry_type rd_data
);
   import swcm_pkg::*;

   slot_entry_type mem [DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/swcm_rsp_reg.sv */
`timescale 1ns / 1ps
// Output register for result beats; lets the sequencer finish while a beat waits.
// Uses swcm_pkg for the result record.
module swcm_rsp_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load_valid,
   input  swcm_pkg::rsp_type              load_data,
   output logic                           load_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_update_valid,
   output logic [swcm_pkg::SID_W-1:0]     rsp_update_stream_num,
   output logic [swcm_pkg::SID_W-1:0]     rsp_update_increment,
   output logic                           rsp_last
);
   import swcm_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // take a new beat when empty or when the held beat leaves this cycle
   assign load_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_ready) begin
         valid_in = load_valid;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_status            = data_ff.status;
   assign rsp_update_valid      = data_ff.update_valid;
   assign rsp_update_stream_num = data_ff.update_sid;
   assign rsp_update_increment  = data_ff.update_inc;
   assign rsp_last              = data_ff.last;

endmodule

/* design/stream_window_credit_manager_core.sv */
`timescale 1ns / 1ps
// Top level of the stream window credit manager: sequencer, connection windows,
// slot valid bits. Uses swcm_pkg, swcm_slot_mem and swcm_rsp_reg.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  kind, slot, stream_num, increment, data_length
//   rsp_      out        rsp_valid/rsp_stall  status, update_valid, update_stream_num,
//                                             update_increment, last
//   csr_      in         csr_valid/csr_ready  data = initial_window
//
// One event at a time. Init, open and connection updates pass from accept through
// dispatch to reply; check and send add load and exec; receive adds load, exec and
// the receive-slot step (and may give two beats). A stream update scans the slot
// memory through its single read port, one slot a cycle, then on a hit executes.
// Synchronous active-high reset; slot contents are not cleared, only valid bits.
// A stalled result beat holds in the output register; the sequencer waits in the
// reply state until the register frees.
module stream_window_credit_manager_core #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // event beats
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_kind,
   input  logic [3:0]                    req_slot,
   input  logic [swcm_pkg::SID_W-1:0]    req_stream_num,
   input  logic [swcm_pkg::INC_W-1:0]    req_increment,
   input  logic [swcm_pkg::LEN_W-1:0]    req_data_length,
   // result beats
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_update_valid,
   output logic [swcm_pkg::SID_W-1:0]    rsp_update_stream_num,
   output logic [swcm_pkg::SID_W-1:0]    rsp_update_increment,
   output logic                          rsp_last,
   // initial window register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swcm_pkg::IWIN_W-1:0]   csr_data
);
   import swcm_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   // control state
   state_type                state_ff, state_in;
   logic [IWIN_W-1:0]        init_win_ff, init_win_in;
   logic [WIN_W-1:0]         conn_send_ff, conn_send_in;
   logic [WIN_W-1:0]         conn_recv_ff, conn_recv_in;
   logic [NUM_SLOTS-1:0]     slot_valid_ff, slot_valid_in;
   logic                     rd_live_ff, rd_live_in;
   logic                     upd0_v_ff, upd0_v_in;
   logic                     upd1_v_ff, upd1_v_in;

   // held event and working values
   logic [2:0]               kind_ff, kind_in;
   logic [3:0]               slot_ff, slot_in;
   logic [SID_W-1:0]         sid_ff, sid_in;
   logic [INC_W-1:0]         inc_ff, inc_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [SLOT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]        hit_idx_ff, hit_idx_in;
   slot_entry_type           ent_ff, ent_in;
   logic [1:0]               status_ff, status_in;
   logic [SID_W-1:0]         upd0_inc_ff, upd0_inc_in;
   logic [SID_W-1:0]         upd1_sid_ff, upd1_sid_in;
   logic [SID_W-1:0]         upd1_inc_ff, upd1_inc_in;

   // memory and output register hookup
   logic                     mem_wr_en;
   logic [SLOT_W-1:0]        mem_wr_addr;
   slot_entry_type           mem_wr_data;
   logic                     mem_rd_en;
   logic [SLOT_W-1:0]        mem_rd_addr;
   slot_entry_type           mem_rd_data;
   logic                     out_load;
   logic                     out_ready;
   rsp_type                  out_data;

   // decoded conditions
   logic [SLOT_W-1:0]        slot_idx;
   logic                     slot_ok, slot_live;
   logic [WIN_W-1:0]         len32, init32, half32;
   logic                     inc_bad;
   logic [WIN_W:0]           conn_sum, ent_sum;
   logic                     conn_over, ent_over;
   logic                     len_gt_init, conn_recv_short, can_send;
   logic [WIN_W-1:0]         conn_recv_left, slot_recv_left;
   logic                     conn_refill, slot_refill, slot_recv_short;
   logic                     search_hit, search_more;

   assign slot_idx  = SLOT_W'(slot_ff);
   assign slot_ok   = int'(slot_ff) < NUM_SLOTS;
   assign slot_live = slot_ok && slot_valid_ff[slot_idx];

   assign len32  = WIN_W'(len_ff);
   assign init32 = WIN_W'(init_win_ff);
   assign half32 = WIN_W'(init_win_ff >> 1);

   // increment must lie in 1 .. 0x7FFFFFFF
   assign inc_bad = (inc_ff == '0) || inc_ff[INC_W-1];

   // 33-bit signed sum; above 0x7FFFFFFF means positive with bit 31 set
   assign conn_sum  = {conn_send_ff[WIN_W-1], conn_send_ff} + {1'b0, inc_ff};
   assign conn_over = !conn_sum[WIN_W] && conn_sum[WIN_W-1];
   assign ent_sum   = {ent_ff.send_win[WIN_W-1], ent_ff.send_win} + {1'b0, inc_ff};
   assign ent_over  = !ent_sum[WIN_W] && ent_sum[WIN_W-1];

   assign len_gt_init     = len32 > init32;
   assign conn_recv_short = $signed(conn_recv_ff) < $signed(len32);
   assign can_send        = ($signed(len32) <= $signed(conn_send_ff)) &&
                            ($signed(len32) <= $signed(ent_ff.send_win));

   assign conn_recv_left  = conn_recv_ff - len32;
   assign conn_refill     = $signed(conn_recv_left) < $signed(half32);
   assign slot_recv_short = $signed(ent_ff.recv_win) < $signed(len32);
   assign slot_recv_left  = ent_ff.recv_win - len32;
   assign slot_refill     = $signed(slot_recv_left) < $signed(half32);

   // scan compare on the data that landed from the previous read
   assign search_hit  = rd_live_ff && slot_valid_ff[rd_idx_ff] &&
                        (mem_rd_data.sid == sid_ff);
   assign search_more = cnt_ff < CNT_W'(NUM_SLOTS);

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (kind_ff)
               KIND_UPDATE: begin
                  state_in = (!inc_bad && (sid_ff != '0)) ? ST_SEARCH : ST_REPLY;
               end
               KIND_CHECK, KIND_SEND: begin
                  state_in = slot_live ? ST_LOAD : ST_REPLY;
               end
               KIND_RECV: begin
                  state_in = (slot_live && !len_gt_init && !conn_recv_short) ?
                             ST_LOAD : ST_REPLY;
               end
               default: begin
                  state_in = ST_REPLY;
               end
            endcase
         end
         ST_SEARCH: begin
            priority if (search_hit) begin
               state_in = ST_EXEC;
            end else if (!search_more && !rd_live_ff) begin
               state_in = ST_REPLY;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_LOAD: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = (kind_ff == KIND_RECV) ? ST_RECV_SLOT : ST_REPLY;
         end
         ST_RECV_SLOT: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            // stay one more beat when both window updates are pending
            if (out_ready && !(upd0_v_ff && upd1_v_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      init_win_in   = init_win_ff;
      conn_send_in  = conn_send_ff;
      conn_recv_in  = conn_recv_ff;
      slot_valid_in = slot_valid_ff;
      upd0_v_in     = upd0_v_ff;
      upd1_v_in     = upd1_v_ff;
      kind_in       = kind_ff;
      slot_in       = slot_ff;
      sid_in        = sid_ff;
      inc_in        = inc_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      hit_idx_in    = hit_idx_ff;
      ent_in        = ent_ff;
      status_in     = status_ff;
      upd0_inc_in   = upd0_inc_ff;
      upd1_sid_in   = upd1_sid_ff;
      upd1_inc_in   = upd1_inc_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = hit_idx_ff;
      mem_wr_data   = ent_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = slot_idx;
      out_load      = 1'b0;
      out_data      = '0;

      if (csr_valid) begin
         init_win_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               slot_in   = req_slot;
               sid_in    = req_stream_num;
               inc_in    = req_increment;
               len_in    = req_data_length;
               status_in = STATUS_OK;
               upd0_v_in = 1'b0;
               upd1_v_in = 1'b0;
            end
         end
         ST_DISPATCH: begin
            cnt_in = '0;
            unique case (kind_ff)
               KIND_INIT: begin
                  conn_send_in = init32;
                  conn_recv_in = init32;
               end
               KIND_OPEN: begin
                  if (slot_ok) begin
                     mem_wr_en            = 1'b1;
                     mem_wr_addr          = slot_idx;
                     mem_wr_data.sid      = sid_ff;
                     mem_wr_data.send_win = init32;
                     mem_wr_data.recv_win = init32;
                     slot_valid_in[slot_idx] = 1'b1;
                  end else begin
                     status_in = STATUS_ERROR;
                  end
               end
               KIND_UPDATE: begin
                  priority if (inc_bad) begin
                     status_in = STATUS_ERROR;
                  end else if (sid_ff == '0) begin
                     if (conn_over) begin
                        status_in = STATUS_ERROR;
                     end else begin
                        conn_send_in = conn_sum[WIN_W-1:0];
                     end
                  end else begin
                     // stream update: the slot scan takes over
                  end
               end
               KIND_CHECK, KIND_SEND: begin
                  if (slot_live) begin
                     mem_rd_en = 1'b1;
                  end else begin
                     status_in = STATUS_ERROR;
                  end
               end
               KIND_RECV: begin
                  if (slot_live && !len_gt_init && !conn_recv_short) begin
                     mem_rd_en = 1'b1;
                  end else begin
                     status_in = STATUS_ERROR;
                  end
               end
               default: begin
                  status_in = STATUS_ERROR;
               end
            endcase
         end
         ST_SEARCH: begin
            // one read issued and one compare done per cycle, lowest slot first
            priority if (search_hit) begin
               ent_in     = mem_rd_data;
               hit_idx_in = rd_idx_ff;
            end else if (search_more) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_ff[SLOT_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               // every slot read; wait for the last compare
            end
         end
         ST_LOAD: begin
            ent_in     = mem_rd_data;
            hit_idx_in = slot_idx;
         end
         ST_EXEC: begin
            unique case (kind_ff)
               KIND_UPDATE: begin
                  if (ent_over) begin
                     status_in = STATUS_ERROR;
                  end else begin
                     mem_wr_en            = 1'b1;
                     mem_wr_data.send_win = ent_sum[WIN_W-1:0];
                  end
               end
               KIND_CHECK: begin
                  status_in = can_send ? STATUS_OK : STATUS_BLOCKED;
               end
               KIND_SEND: begin
                  // no check: windows wrap
                  conn_send_in         = conn_send_ff - len32;
                  mem_wr_en            = 1'b1;
                  mem_wr_data.send_win = ent_ff.send_win - len32;
               end
               KIND_RECV: begin
                  if (conn_refill) begin
                     conn_recv_in = init32;
                     upd0_v_in    = 1'b1;
                     upd0_inc_in  = SID_W'(init32 - conn_recv_left);
                  end else begin
                     conn_recv_in = conn_recv_left;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RECV_SLOT: begin
            if (slot_recv_short) begin
               status_in = STATUS_ERROR;
            end else begin
               mem_wr_en = 1'b1;
               if (slot_refill) begin
                  mem_wr_data.recv_win = init32;
                  upd1_v_in   = 1'b1;
                  upd1_sid_in = ent_ff.sid;
                  upd1_inc_in = SID_W'(init32 - slot_recv_left);
               end else begin
                  mem_wr_data.recv_win = slot_recv_left;
               end
            end
         end
         ST_REPLY: begin
            out_load = 1'b1;
            priority if (upd0_v_ff) begin
               out_data.status       = upd1_v_ff ? STATUS_OK : status_ff;
               out_data.update_valid = 1'b1;
               out_data.update_sid   = '0;
               out_data.update_inc   = upd0_inc_ff;
               out_data.last         = !upd1_v_ff;
            end else if (upd1_v_ff) begin
               out_data.status       = status_ff;
               out_data.update_valid = 1'b1;
               out_data.update_sid   = upd1_sid_ff;
               out_data.update_inc   = upd1_inc_ff;
               out_data.last         = 1'b1;
            end else begin
               out_data.status       = status_ff;
               out_data.last         = 1'b1;
            end
            if (out_ready) begin
               // drop the connection beat first, then the stream beat
               if (upd0_v_ff) begin
                  upd0_v_in = 1'b0;
               end else begin
                  upd1_v_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      rd_live_in = mem_rd_en;
      if (mem_rd_en) begin
         rd_idx_in = mem_rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         init_win_ff   <= DEFAULT_WINDOW;
         conn_send_ff  <= WIN_W'(DEFAULT_WINDOW);
         conn_recv_ff  <= WIN_W'(DEFAULT_WINDOW);
         slot_valid_ff <= '0;
         rd_live_ff    <= 1'b0;
         upd0_v_ff     <= 1'b0;
         upd1_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_win_ff   <= init_win_in;
         conn_send_ff  <= conn_send_in;
         conn_recv_ff  <= conn_recv_in;
         slot_valid_ff <= slot_valid_in;
         rd_live_ff    <= rd_live_in;
         upd0_v_ff     <= upd0_v_in;
         upd1_v_ff     <= upd1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      slot_ff     <= slot_in;
      sid_ff      <= sid_in;
      inc_ff      <= inc_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      ent_ff      <= ent_in;
      status_ff   <= status_in;
      upd0_inc_ff <= upd0_inc_in;
      upd1_sid_ff <= upd1_sid_in;
      upd1_inc_ff <= upd1_inc_in;
   end

   swcm_slot_mem #(
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   swcm_rsp_reg u_rsp_reg (
      .clock                 (clock),
      .reset                 (reset),
      .load_valid            (out_load),
      .load_data             (out_data),
      .load_ready            (out_ready),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_update_valid      (rsp_update_valid),
      .rsp_update_stream_num (rsp_update_stream_num),
      .rsp_update_increment  (rsp_update_increment),
      .rsp_last              (rsp_last)
   );

   // one event in flight: the cycle after an accept the input is held off
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("event accepted while another is in flight");

   a_plain_beat_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_update_valid) |->
      (rsp_update_stream_num == '0 && rsp_update_increment == '0))
      else $error("beat without update carries update fields");

   a_first_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_update_valid && rsp_status == STATUS_OK))
      else $error("leading beat is not a clean window update");

   a_update_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_update_valid) |-> (rsp_update_increment != '0))
      else $error("window update with zero increment");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> (int'(mem_rd_addr) < NUM_SLOTS))
      else $error("slot memory read beyond table");

endmodule
